[sv/tntp_pkg.sv]
// Package for the two-target nearest point tracker: types, constants, sequencer states.
`timescale 1ns / 1ps

package tntp_pkg;

    // Upscale factor from downsampled to full sensor pixels (1 to 8)
    localparam int unsigned DOWNSAMPLE   = 1;
    localparam int unsigned FULL_X_W     = 15;
    localparam int unsigned POS_W        = 16;
    localparam int unsigned SCALE_W      = 16;
    localparam int unsigned FWIDTH_W     = 13;
    localparam int unsigned DT_W         = 24;
    localparam int unsigned VEL_W        = 32;
    localparam int unsigned DIST_W       = 34;
    localparam int unsigned SQ_W         = 32;

    // Shared multiplier operand and product widths
    localparam int unsigned MUL_A_W      = 16;
    localparam int unsigned MUL_B_W      = 20;
    localparam int unsigned MUL_P_W      = MUL_A_W + MUL_B_W;

    // Q4.12 fraction bits
    localparam int unsigned FRAC_W       = 12;

    // Microseconds per second, as a multiplier operand
    localparam logic [MUL_B_W-1:0] USEC_PER_SEC = 20'd1000000;

    // Restoring divider: one quotient bit per cycle over the full product
    localparam int unsigned DIV_STEPS    = MUL_P_W;
    localparam int unsigned DIV_CNT_W    = 6;
    localparam int unsigned REM_W        = DT_W + 1;

    // Saturation limits of a 32-bit signed velocity
    localparam logic [MUL_P_W-1:0] VEL_POS_MAX = 36'h0_7FFF_FFFF;
    localparam logic [MUL_P_W-1:0] VEL_NEG_MAX = 36'h0_8000_0000;

    // Configuration port
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SCALE = 2'd2;

    localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [SCALE_W-1:0]  WIDTH_SCALE_RST  = 16'd4096;
    localparam logic [SCALE_W-1:0]  HEIGHT_SCALE_RST = 16'd4096;

    // Input word kinds
    localparam logic KIND_POINT     = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [11:0]     point_x;
        logic [11:0]     point_y;
        logic [DT_W-1:0] delta_time_us;
    } tntp_in_t;

    typedef struct packed {
        logic [POS_W-1:0]        one_pos_x;
        logic [POS_W-1:0]        one_pos_y;
        logic [POS_W-1:0]        two_pos_x;
        logic [POS_W-1:0]        two_pos_y;
        logic signed [VEL_W-1:0] one_vel_x;
        logic signed [VEL_W-1:0] one_vel_y;
        logic signed [VEL_W-1:0] two_vel_x;
        logic signed [VEL_W-1:0] two_vel_y;
        logic                    one_found;
        logic                    two_found;
    } tntp_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAPX,
        ST_MAPY,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_VMUL,
        ST_VDIV,
        ST_VSAT,
        ST_DONE
    } tntp_state_t;

endpackage

[sv/two_target_nearest_point_tracker.sv]
// Top level of the two-target nearest point tracker: sequencer, shared multiplier, divider.
// Point word: accepted in idle, then map x, map y, square x, square y and compare, back to idle;
// the next word is taken once idle again. A point exactly at mid-frame leaves the sequencer idle.
// End-of-frame word: per axis one multiply, 36 restoring divider steps and one saturate step,
// four axes in turn through one divider; then the result word loads once the result register is free.
// The result register holds a word until taken while point words are still accepted.
// Reset (aresetn low, synchronous): positions and candidates cleared, registers to defaults.
`timescale 1ns / 1ps

module two_target_nearest_point_tracker
    import tntp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tntp_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tntp_out_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    tntp_state_t state_reg, state_next;

    // Configuration
    logic [FWIDTH_W-1:0] frame_width_reg;
    logic [SCALE_W-1:0]  width_scale_reg;
    logic [SCALE_W-1:0]  height_scale_reg;

    // Tracker state
    logic [POS_W-1:0]  pos_x_reg  [2];
    logic [POS_W-1:0]  pos_y_reg  [2];
    logic [POS_W-1:0]  old_x_reg  [2];
    logic [POS_W-1:0]  old_y_reg  [2];
    logic [POS_W-1:0]  cand_x_reg [2];
    logic [POS_W-1:0]  cand_y_reg [2];
    logic [DIST_W-1:0] cand_d_reg [2];
    logic [1:0]        cand_v_reg;

    // Point work registers
    logic [11:0]       px_reg;
    logic [11:0]       py_reg;
    logic              side_reg;
    logic [POS_W-1:0]  tx_reg;
    logic [POS_W-1:0]  ty_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;

    // Frame-end work registers
    logic [DT_W-1:0]      dt_reg;
    logic [1:0]           found_reg;
    logic [1:0]           axis_reg;
    logic                 neg_reg;
    logic [MUL_P_W-1:0]   div_q_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [VEL_W-1:0]     vel_reg [4];

    logic      m_valid_reg, m_valid_next;
    tntp_out_t out_reg;

    // Handshake
    logic in_fire;
    logic out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    // Mid-frame split of the incoming point
    logic [FULL_X_W-1:0] in_full_x;
    logic [FWIDTH_W-2:0] mid;

    assign in_full_x = FULL_X_W'(s_data.point_x) * FULL_X_W'(DOWNSAMPLE);
    assign mid       = frame_width_reg[FWIDTH_W-1:1];

    // Shared multiplier operand selection
    logic [FULL_X_W-1:0] full_x;
    logic [FULL_X_W-1:0] full_y;
    logic [POS_W-1:0]    tgt_x;
    logic [POS_W-1:0]    tgt_y;
    logic [POS_W-1:0]    dx;
    logic [POS_W-1:0]    dy;
    logic [POS_W-1:0]    v_now;
    logic [POS_W-1:0]    v_old;
    logic                v_neg;
    logic [POS_W-1:0]    v_mag;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_p;
    logic [POS_W-1:0]    map_sat;

    assign full_x = FULL_X_W'(px_reg) * FULL_X_W'(DOWNSAMPLE);
    assign full_y = FULL_X_W'(py_reg) * FULL_X_W'(DOWNSAMPLE);
    assign tgt_x  = pos_x_reg[side_reg];
    assign tgt_y  = pos_y_reg[side_reg];
    assign dx     = (tx_reg > tgt_x) ? (tx_reg - tgt_x) : (tgt_x - tx_reg);
    assign dy     = (ty_reg > tgt_y) ? (ty_reg - tgt_y) : (tgt_y - ty_reg);
    assign v_now  = axis_reg[0] ? pos_y_reg[axis_reg[1]] : pos_x_reg[axis_reg[1]];
    assign v_old  = axis_reg[0] ? old_y_reg[axis_reg[1]] : old_x_reg[axis_reg[1]];
    assign v_neg  = (v_now < v_old);
    assign v_mag  = v_neg ? (v_old - v_now) : (v_now - v_old);

    always_comb begin
        case (state_reg)
            ST_MAPX: begin
                mul_a = MUL_A_W'(full_x);
                mul_b = MUL_B_W'(width_scale_reg);
            end
            ST_MAPY: begin
                mul_a = MUL_A_W'(full_y);
                mul_b = MUL_B_W'(height_scale_reg);
            end
            ST_SQX: begin
                mul_a = dx;
                mul_b = MUL_B_W'(dx);
            end
            ST_SQY: begin
                mul_a = dy;
                mul_b = MUL_B_W'(dy);
            end
            ST_VMUL: begin
                mul_a = v_mag;
                mul_b = USEC_PER_SEC;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // Q4.12 drop and clamp to the 16-bit position range
    assign map_sat = (|mul_p[MUL_P_W-1:FRAC_W+POS_W]) ? '1 : mul_p[FRAC_W+POS_W-1:FRAC_W];

    // Squared distance against the current candidate
    logic [DIST_W-1:0] dist_sum;
    logic              take_cand;

    assign dist_sum  = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    assign take_cand = !cand_v_reg[side_reg] || (dist_sum < cand_d_reg[side_reg]);

    // Restoring divider step
    logic [REM_W-1:0] rem_sh;
    logic             rem_ge;
    logic [REM_W-1:0] rem_step;

    assign rem_sh   = {rem_reg[REM_W-2:0], div_q_reg[MUL_P_W-1]};
    assign rem_ge   = (rem_sh >= REM_W'(dt_reg));
    assign rem_step = rem_ge ? (rem_sh - REM_W'(dt_reg)) : rem_sh;

    // Saturated, signed velocity of the finished axis
    logic [VEL_W-1:0] vel_sat;

    always_comb begin
        if (dt_reg == '0) begin
            vel_sat = '0;
        end else if (neg_reg) begin
            vel_sat = (div_q_reg > VEL_NEG_MAX) ? VEL_NEG_MAX[VEL_W-1:0]
                                                : (VEL_W'(0) - div_q_reg[VEL_W-1:0]);
        end else begin
            vel_sat = (div_q_reg > VEL_POS_MAX) ? VEL_POS_MAX[VEL_W-1:0]
                                                : div_q_reg[VEL_W-1:0];
        end
    end

    // Next state and result valid
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_data.kind == KIND_FRAME_END) begin
                        state_next = ST_VMUL;
                    end else if (FULL_X_W'(mid) != in_full_x) begin
                        state_next = ST_MAPX;
                    end
                end
            end
            ST_MAPX: state_next = ST_MAPY;
            ST_MAPY: state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_CMP;
            ST_CMP:  state_next = ST_IDLE;
            ST_VMUL: state_next = ST_VDIV;
            ST_VDIV: begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_VSAT;
                end
            end
            ST_VSAT: state_next = (axis_reg == 2'd3) ? ST_DONE : ST_VMUL;
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Configuration writes; unknown indices are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            width_scale_reg  <= WIDTH_SCALE_RST;
            height_scale_reg <= HEIGHT_SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FWIDTH_W-1:0];
                CFG_WIDTH_SCALE:  width_scale_reg  <= cfg_wdata;
                CFG_HEIGHT_SCALE: height_scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Target positions and candidate flags (control state, cleared by reset)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg[0] <= '0;
            pos_x_reg[1] <= '0;
            pos_y_reg[0] <= '0;
            pos_y_reg[1] <= '0;
            cand_v_reg   <= '0;
        end else if (in_fire && (s_data.kind == KIND_FRAME_END)) begin
            // Frame end: targets with a candidate take its position
            for (int t = 0; t < 2; t++) begin
                if (cand_v_reg[t]) begin
                    pos_x_reg[t] <= cand_x_reg[t];
                    pos_y_reg[t] <= cand_y_reg[t];
                end
            end
            cand_v_reg <= '0;
        end else if ((state_reg == ST_CMP) && take_cand) begin
            cand_v_reg[side_reg] <= 1'b1;
        end
    end

    // Point datapath
    always_ff @(posedge aclk) begin
        if (in_fire && (s_data.kind == KIND_POINT)) begin
            px_reg   <= s_data.point_x;
            py_reg   <= s_data.point_y;
            side_reg <= (in_full_x > FULL_X_W'(mid));
        end
        case (state_reg)
            ST_MAPX: tx_reg  <= map_sat;
            ST_MAPY: ty_reg  <= map_sat;
            ST_SQX:  sqx_reg <= mul_p[SQ_W-1:0];
            ST_SQY:  sqy_reg <= mul_p[SQ_W-1:0];
            ST_CMP: begin
                if (take_cand) begin
                    cand_d_reg[side_reg] <= dist_sum;
                    cand_x_reg[side_reg] <= tx_reg;
                    cand_y_reg[side_reg] <= ty_reg;
                end
            end
            default: ;
        endcase
    end

    // Frame-end datapath: velocity per axis through the divider
    always_ff @(posedge aclk) begin
        if (in_fire && (s_data.kind == KIND_FRAME_END)) begin
            dt_reg       <= s_data.delta_time_us;
            found_reg    <= cand_v_reg;
            old_x_reg[0] <= pos_x_reg[0];
            old_x_reg[1] <= pos_x_reg[1];
            old_y_reg[0] <= pos_y_reg[0];
            old_y_reg[1] <= pos_y_reg[1];
            axis_reg     <= '0;
        end
        case (state_reg)
            ST_VMUL: begin
                neg_reg   <= v_neg;
                div_q_reg <= mul_p;
                rem_reg   <= '0;
                cnt_reg   <= '0;
            end
            ST_VDIV: begin
                rem_reg   <= rem_step;
                div_q_reg <= {div_q_reg[MUL_P_W-2:0], rem_ge};
                cnt_reg   <= cnt_reg + 1'b1;
            end
            ST_VSAT: begin
                vel_reg[axis_reg] <= vel_sat;
                axis_reg          <= axis_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Result word register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.one_pos_x <= pos_x_reg[0];
            out_reg.one_pos_y <= pos_y_reg[0];
            out_reg.two_pos_x <= pos_x_reg[1];
            out_reg.two_pos_y <= pos_y_reg[1];
            out_reg.one_vel_x <= vel_reg[0];
            out_reg.one_vel_y <= vel_reg[1];
            out_reg.two_vel_x <= vel_reg[2];
            out_reg.two_vel_y <= vel_reg[3];
            out_reg.one_found <= found_reg[0];
            out_reg.two_found <= found_reg[1];
        end
    end

    // Checks
    a_busy_after_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (s_data.kind == KIND_FRAME_END)) |=> !s_ready)
        else $error("tracker ready straight after a frame-end word");

    a_cand_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (s_data.kind == KIND_FRAME_END)) |=> (cand_v_reg == 2'b00))
        else $error("candidates not cleared at frame end");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the done step");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_VDIV) && (dt_reg != '0)) |-> (rem_reg < REM_W'(dt_reg)))
        else $error("divider remainder not below divisor");

endmodule
